// File: sv/efp_pkg.sv
// ----------------------------------------------------------------------------
// efp_pkg: shared types and constants of the elevator floor planner
// Event codes, floor codes, register indexes and the beat structs.
// ----------------------------------------------------------------------------
package efp_pkg;

    // event codes of one input beat
    localparam logic [3:0] CMD_TICK         = 4'd0;
    localparam logic [3:0] CMD_FLOOR1       = 4'd1;
    localparam logic [3:0] CMD_FLOOR2       = 4'd2;
    localparam logic [3:0] CMD_FLOOR3       = 4'd3;
    localparam logic [3:0] CMD_ARRIVED      = 4'd4;
    localparam logic [3:0] CMD_LEFT         = 4'd5;
    localparam logic [3:0] CMD_DOORS_CLOSED = 4'd6;
    localparam logic [3:0] CMD_DOORS_OPEN   = 4'd7;
    localparam logic [3:0] CMD_STOP_PRESS   = 4'd8;
    localparam logic [3:0] CMD_STOP_RELEASE = 4'd9;

    // motor direction codes
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // floor codes; zero marks an empty queue slot
    localparam logic [1:0] FLOOR_NONE = 2'd0;
    localparam logic [1:0] FLOOR_1    = 2'd1;
    localparam logic [1:0] FLOOR_2    = 2'd2;
    localparam logic [1:0] FLOOR_3    = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_FLOOR1_POS  = 3'd0;
    localparam logic [2:0] REG_FLOOR2_POS  = 3'd1;
    localparam logic [2:0] REG_FLOOR3_POS  = 3'd2;
    localparam logic [2:0] REG_SAFE_STOP   = 3'd3;
    localparam logic [2:0] REG_DWELL_TICKS = 3'd4;

    // settle counter stops counting above this value
    localparam logic [7:0] SETTLE_LIMIT = 8'd50;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [1:0]         car_direction;
        logic signed [15:0] car_position;
    } t_item;

    typedef struct packed {
        logic               target_valid;
        logic signed [15:0] target_position;
        logic               motor_stop;
    } t_result;

    // sequencer commands to the datapath
    typedef struct packed {
        logic load;  // capture the input beat
        logic exec;  // update state and register the result
    } t_ctrl;

endpackage

// File: sv/efp_ctrl.sv
// ----------------------------------------------------------------------------
// efp_ctrl: sequencer of the elevator floor planner
// Two-state machine: waits for start, then runs the execute state and returns to idle.
// ----------------------------------------------------------------------------
module efp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output efp_pkg::t_ctrl o_ctrl
);
    import efp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_busy      = (r_state == ST_EXEC);
    assign o_ctrl.load = (r_state == ST_IDLE) && i_start;
    assign o_ctrl.exec = (r_state == ST_EXEC);

endmodule

// File: sv/efp_datapath.sv
// ----------------------------------------------------------------------------
// efp_datapath: planner state, request queue and result register
// Holds the configuration, the queue and the dwell/settle counters, and
// applies one captured event per execute command.
// ----------------------------------------------------------------------------
module efp_datapath #(
    parameter int QUEUE_DEPTH = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  efp_pkg::t_ctrl   i_ctrl,
    input  efp_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_addr,
    input  logic [15:0]      i_cfg_data,
    output logic             o_result_valid,
    output efp_pkg::t_result o_result
);
    import efp_pkg::*;

    // configuration
    logic signed [15:0] r_floor1_pos;
    logic signed [15:0] r_floor2_pos;
    logic signed [15:0] r_floor3_pos;
    logic [14:0]        r_safe_stop;
    logic [15:0]        r_dwell_ticks;

    // planner state
    logic [1:0]  r_queue [QUEUE_DEPTH];
    logic [1:0]  n_queue [QUEUE_DEPTH];
    logic [1:0]  r_target;
    logic [1:0]  n_target;
    logic [1:0]  r_current;
    logic [1:0]  n_current;
    logic        r_at_floor;
    logic        n_at_floor;
    logic        r_doors_shut;
    logic        n_doors_shut;
    logic [15:0] r_dwell;
    logic [15:0] n_dwell;
    logic [7:0]  r_settle;
    logic [7:0]  n_settle;

    // captured beat and result
    t_item   r_item;
    t_result r_result;
    t_result n_result;
    logic    r_result_valid;

    // floor-two safe-stop check in 18-bit signed arithmetic
    logic signed [17:0] w_pos;
    logic signed [17:0] w_mid;
    logic signed [17:0] w_margin;
    logic               w_mid_ok;

    assign w_pos    = {{2{r_item.car_position[15]}}, r_item.car_position};
    assign w_mid    = {{2{r_floor2_pos[15]}}, r_floor2_pos};
    assign w_margin = {3'b000, r_safe_stop};
    assign w_mid_ok = ((r_item.car_direction == DIR_UP)   && ((w_pos + w_margin) <= w_mid)) ||
                      ((r_item.car_direction == DIR_DOWN) && ((w_pos - w_margin) >= w_mid));

    // next planner state and result
    always_comb begin
        logic       dup;
        logic       placed;
        logic [1:0] fl;
        logic [1:0] tfl;
        n_queue      = r_queue;
        n_target     = r_target;
        n_current    = r_current;
        n_at_floor   = r_at_floor;
        n_doors_shut = r_doors_shut;
        n_dwell      = r_dwell;
        n_settle     = r_settle;
        n_result     = '0;
        dup          = 1'b0;
        placed       = 1'b0;
        fl           = r_item.cmd[1:0];
        tfl          = r_target;
        if (i_ctrl.exec) begin
            case (r_item.cmd)
                CMD_TICK: begin
                    if (r_at_floor && (r_item.car_direction == DIR_IDLE) &&
                        (r_dwell < r_dwell_ticks)) begin
                        // dwell at the reached floor
                        n_dwell  = r_dwell + 16'd1;
                        n_settle = '0;
                        if (r_target != r_current) begin
                            n_current = r_queue[0];
                            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                                n_queue[i] = r_queue[i + 1];
                            end
                            n_queue[QUEUE_DEPTH - 1] = FLOOR_NONE;
                        end
                    end else begin
                        // issue target while the doors are shut
                        if (r_doors_shut) begin
                            if (r_queue[0] != FLOOR_NONE) begin
                                tfl = r_queue[0];
                            end
                            n_target = tfl;
                            n_result.target_valid = 1'b1;
                            if (tfl == FLOOR_1) begin
                                n_result.target_position = r_floor1_pos;
                            end else if (tfl == FLOOR_2) begin
                                n_result.target_position = r_floor2_pos;
                            end else begin
                                n_result.target_position = r_floor3_pos;
                            end
                        end
                        if (r_settle > SETTLE_LIMIT) begin
                            n_dwell = '0;
                        end else begin
                            n_settle = r_settle + 8'd1;
                        end
                    end
                end
                CMD_FLOOR1, CMD_FLOOR2, CMD_FLOOR3: begin
                    if (r_target != fl) begin
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                            if (r_queue[i] == fl) begin
                                dup = 1'b1;
                            end
                        end
                        if (!dup) begin
                            if ((fl == FLOOR_2) && w_mid_ok) begin
                                // jump to the head, last entry falls off
                                for (int i = 1; i < QUEUE_DEPTH; i++) begin
                                    n_queue[i] = r_queue[i - 1];
                                end
                                n_queue[0] = fl;
                            end else begin
                                // first empty slot; dropped when full
                                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                                    if (!placed && (r_queue[i] == FLOOR_NONE)) begin
                                        n_queue[i] = fl;
                                        placed     = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                CMD_ARRIVED:      n_at_floor   = 1'b1;
                CMD_LEFT:         n_at_floor   = 1'b0;
                CMD_DOORS_CLOSED: n_doors_shut = 1'b1;
                CMD_DOORS_OPEN:   n_doors_shut = 1'b0;
                CMD_STOP_PRESS:   n_result.motor_stop = 1'b1;
                default: begin
                    // stop released and unused codes: no effect
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor1_pos  <= 16'sd0;
            r_floor2_pos  <= 16'sd400;
            r_floor3_pos  <= 16'sd800;
            r_safe_stop   <= 15'd20;
            r_dwell_ticks <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FLOOR1_POS:  r_floor1_pos  <= i_cfg_data;
                REG_FLOOR2_POS:  r_floor2_pos  <= i_cfg_data;
                REG_FLOOR3_POS:  r_floor3_pos  <= i_cfg_data;
                REG_SAFE_STOP:   r_safe_stop   <= i_cfg_data[14:0];
                REG_DWELL_TICKS: r_dwell_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // planner state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_queue[i] <= FLOOR_NONE;
            end
            r_target       <= FLOOR_1;
            r_current      <= FLOOR_1;
            r_at_floor     <= 1'b1;
            r_doors_shut   <= 1'b0;
            r_dwell        <= '0;
            r_settle       <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_queue        <= n_queue;
            r_target       <= n_target;
            r_current      <= n_current;
            r_at_floor     <= n_at_floor;
            r_doors_shut   <= n_doors_shut;
            r_dwell        <= n_dwell;
            r_settle       <= n_settle;
            r_result_valid <= i_ctrl.exec;
        end
    end

    // beat capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_item <= i_item;
        end
        if (i_ctrl.exec) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

// File: sv/elevator_floor_planner_core.sv
// ----------------------------------------------------------------------------
// elevator_floor_planner_core: three-floor elevator planner
// Top level joining the sequencer and the planner datapath.
// ----------------------------------------------------------------------------
// An event is taken when i_start is high and o_busy is low. Each event passes
// through the capture cycle and then the execute cycle, in which the sequencer
// holds o_busy high, so no new event is taken until that one has run. The
// result beat shows on o_result with o_result_valid high for exactly one
// cycle, the cycle after the execute cycle; it is not held, so the receiver
// must take it then. Every event, ticks and ignored codes included, gives one
// result beat. Configuration writes through i_cfg_we/i_cfg_addr/i_cfg_data
// take effect at once and belong in idle time.
// ----------------------------------------------------------------------------
module elevator_floor_planner_core #(
    parameter int QUEUE_DEPTH = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  efp_pkg::t_item   i_item,
    output logic             o_result_valid,
    output efp_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_addr,
    input  logic [15:0]      i_cfg_data
);
    import efp_pkg::*;

    t_ctrl w_ctrl;

    // sequencer
    efp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_ctrl  (w_ctrl)
    );

    // planner datapath
    efp_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// File: sv/efp_checker.sv
// ----------------------------------------------------------------------------
// efp_checker: port-level checks of the elevator floor planner
// Watches event acceptance, execute timing and result beats.
// ----------------------------------------------------------------------------
module efp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input logic             o_result_valid,
    input efp_pkg::t_result o_result
);
    import efp_pkg::*;

    // an accepted event keeps the block busy for one cycle only
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy ##1 !o_busy))
        else $error("busy window after accept is wrong");

    // every accepted event yields its result beat after its execute cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_result_valid)
        else $error("result beat missing after accepted event");

    // a result beat only follows an execute cycle
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(o_busy) && !o_busy))
        else $error("result beat without execute cycle");

    // no target position without a target, and stop never comes with a target
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_result.target_valid || (o_result.target_position == 16'sd0)) &&
                            !(o_result.target_valid && o_result.motor_stop)))
        else $error("inconsistent result fields");

endmodule

bind elevator_floor_planner_core efp_checker u_efp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

// File: bench/efp_plan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// efp_plan_checker: result predictor and scoreboard for the floor planner
// Watches the event, result and register channels. Each accepted event runs
// through a local model of the planner, and each result beat is compared
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module efp_plan_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  efp_pkg::t_item   i_item,
    input  logic             i_result_valid,
    input  efp_pkg::t_result i_result,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_addr,
    input  logic [15:0]      i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);
    import efp_pkg::*;

    localparam int DEPTH = 3;

    // planner registers
    logic signed [15:0] pos_floor1;
    logic signed [15:0] pos_floor2;
    logic signed [15:0] pos_floor3;
    logic [14:0]        stop_margin;
    logic [15:0]        dwell_limit;

    // planner state
    logic [1:0]  req_queue [0:DEPTH-1];
    logic [1:0]  tgt_floor;
    logic [1:0]  cur_floor;
    logic        car_at_floor;
    logic        doors_are_shut;
    logic [15:0] dwell_cnt;
    logic [7:0]  settle_cnt;

    t_result planned_results[$];
    int      mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic clear_planner();
        int k;
        pos_floor1     = 16'sd0;
        pos_floor2     = 16'sd400;
        pos_floor3     = 16'sd800;
        stop_margin    = 15'd20;
        dwell_limit    = 16'd100;
        for (k = 0; k < DEPTH; k++) req_queue[k] = FLOOR_NONE;
        tgt_floor      = FLOOR_1;
        cur_floor      = FLOOR_1;
        car_at_floor   = 1'b1;
        doors_are_shut = 1'b0;
        dwell_cnt      = '0;
        settle_cnt     = '0;
    endtask

    // floor two can still be served when the car has room to brake before it
    function automatic bit floor2_on_the_way(logic [1:0] dir, logic signed [15:0] pos);
        int mid;
        int margin;
        int here;
        mid    = int'(pos_floor2);
        margin = int'({1'b0, stop_margin});
        here   = int'(pos);
        if (dir == DIR_UP && here + margin <= mid) return 1'b1;
        if (dir == DIR_DOWN && here - margin >= mid) return 1'b1;
        return 1'b0;
    endfunction

    // no duplicates; floor two may jump the line; a full queue drops the call
    function automatic void queue_request(logic [1:0] fl, logic [1:0] dir,
                                          logic signed [15:0] pos);
        int k;
        for (k = 0; k < DEPTH; k++)
            if (req_queue[k] == fl) return;
        if (fl == FLOOR_2 && floor2_on_the_way(dir, pos)) begin
            for (k = DEPTH - 1; k > 0; k--) req_queue[k] = req_queue[k-1];
            req_queue[0] = fl;
            return;
        end
        for (k = 0; k < DEPTH; k++)
            if (req_queue[k] == FLOOR_NONE) begin
                req_queue[k] = fl;
                return;
            end
    endfunction

    function automatic logic [1:0] pop_request();
        logic [1:0] head;
        int k;
        head = req_queue[0];
        for (k = 0; k < DEPTH - 1; k++) req_queue[k] = req_queue[k+1];
        req_queue[DEPTH-1] = FLOOR_NONE;
        return head;
    endfunction

    // advance the planner by one event and return the beat it should produce
    function automatic t_result predict_event(t_item it);
        t_result r;
        r = '0;
        case (it.cmd)
            CMD_TICK: begin
                if (car_at_floor && it.car_direction == DIR_IDLE && dwell_cnt < dwell_limit) begin
                    dwell_cnt  = dwell_cnt + 16'd1;
                    settle_cnt = '0;
                    if (tgt_floor != cur_floor) cur_floor = pop_request();
                end else begin
                    if (doors_are_shut) begin
                        if (req_queue[0] != FLOOR_NONE) tgt_floor = req_queue[0];
                        case (tgt_floor)
                            FLOOR_1: r.target_position = pos_floor1;
                            FLOOR_2: r.target_position = pos_floor2;
                            default: r.target_position = pos_floor3;
                        endcase
                        r.target_valid = 1'b1;
                    end
                    if (settle_cnt > SETTLE_LIMIT) dwell_cnt = '0;
                    else settle_cnt = settle_cnt + 8'd1;
                end
            end
            CMD_FLOOR1, CMD_FLOOR2, CMD_FLOOR3: begin
                if ({2'b00, tgt_floor} != it.cmd)
                    queue_request(it.cmd[1:0], it.car_direction, it.car_position);
            end
            CMD_ARRIVED:      car_at_floor   = 1'b1;
            CMD_LEFT:         car_at_floor   = 1'b0;
            CMD_DOORS_CLOSED: doors_are_shut = 1'b1;
            CMD_DOORS_OPEN:   doors_are_shut = 1'b0;
            CMD_STOP_PRESS:   r.motor_stop   = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, t_result want, t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s: exp valid=%0b pos=%0d stop=%0b, got valid=%0b pos=%0d stop=%0b",
                     $time, what, want.target_valid, want.target_position, want.motor_stop,
                     got.target_valid, got.target_position, got.motor_stop);
    endtask

    // compare, then track registers, then predict newly accepted events
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_planner();
            planned_results.delete();
        end else begin
            if (i_result_valid) begin
                if (planned_results.size() == 0) begin
                    report("result beat with nothing pending", '0, i_result);
                end else begin
                    want = planned_results.pop_front();
                    if (i_result.target_valid !== want.target_valid ||
                        i_result.target_position !== want.target_position ||
                        i_result.motor_stop !== want.motor_stop)
                        report("result mismatch", want, i_result);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_FLOOR1_POS:  pos_floor1  = i_cfg_data;
                    REG_FLOOR2_POS:  pos_floor2  = i_cfg_data;
                    REG_FLOOR3_POS:  pos_floor3  = i_cfg_data;
                    REG_SAFE_STOP:   stop_margin = i_cfg_data[14:0];
                    REG_DWELL_TICKS: dwell_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) planned_results.push_back(predict_event(i_item));
        end
        o_pending <= planned_results.size();
    end

endmodule

// File: bench/elevator_floor_planner_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elevator_floor_planner_core_tb: top of the floor planner testbench
// Drives a directed event list, then phases of random trips, long cruises
// and noise under several register settings, with bursty event timing.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module elevator_floor_planner_core_tb;
    import efp_pkg::*;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam logic [1:0] DIR_INVALID   = 2'd3;
    localparam logic [2:0] REG_UNUSED    = 3'd7;
    localparam int         PHASE_ITEMS   = 172;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       item = '0;
    logic        result_valid;
    t_result     result;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;
    int          pending;
    int          fail_count;

    // mirror of register values used to aim positions at interesting spots
    int floor_pos [0:2] = '{0, 400, 800};
    int margin_now = 20;
    int burst_left = 0;
    int phase_items;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    elevator_floor_planner_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_item         (item),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data)
    );

    efp_plan_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item),
        .i_result_valid (result_valid),
        .i_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // one event beat; bursts of random length separated by random gaps
    task automatic issue_event(logic [3:0] cmd, logic [1:0] dir, logic signed [15:0] pos);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 60);
            else burst_left = $urandom_range(1, 8);
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        start              = 1'b1;
        item.cmd           = cmd;
        item.car_direction = dir;
        item.car_position  = pos;
        do @(posedge clk); while (busy);
        phase_items++;
    endtask

    // hold events until every pending result beat has come back
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [15:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_addr = addr;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    function automatic logic [3:0] pick_button();
        case ($urandom_range(0, 2))
            0:       return CMD_FLOOR1;
            1:       return CMD_FLOOR2;
            default: return CMD_FLOOR3;
        endcase
    endfunction

    function automatic logic [1:0] moving_dir();
        return $urandom_range(0, 1) ? DIR_UP : DIR_DOWN;
    endfunction

    function automatic logic [1:0] any_dir();
        case ($urandom_range(0, 2))
            0:       return DIR_IDLE;
            1:       return DIR_UP;
            default: return DIR_DOWN;
        endcase
    endfunction

    // random, near the floor-two braking edge, or near a floor
    function automatic logic signed [15:0] pick_pos();
        int p;
        case ($urandom_range(0, 3))
            0, 1: p = $urandom;
            2:    p = floor_pos[1] + ($urandom_range(0, 1) ? margin_now : -margin_now)
                      + $urandom_range(0, 6) - 3;
            default: p = floor_pos[$urandom_range(0, 2)] + $urandom_range(0, 20) - 10;
        endcase
        return p[15:0];
    endfunction

    initial begin
        int n;
        int kind;
        logic [15:0] regs [0:4];
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed events at reset register values
        phase_items = 0;
        issue_event(CMD_STOP_PRESS, DIR_IDLE, 16'sd0);
        issue_event(CMD_STOP_RELEASE, DIR_UP, 16'sd0);
        issue_event(CMD_UNUSED_HI, DIR_INVALID, 16'sh8000);
        issue_event(CMD_TICK, DIR_IDLE, 16'sd0);
        issue_event(CMD_FLOOR1, DIR_IDLE, 16'sd0);
        issue_event(CMD_FLOOR3, DIR_IDLE, 16'sd0);
        issue_event(CMD_FLOOR2, DIR_UP, 16'sd380);
        issue_event(CMD_FLOOR3, DIR_UP, 16'sd100);
        issue_event(CMD_FLOOR2, DIR_UP, 16'sd390);
        issue_event(CMD_DOORS_CLOSED, DIR_IDLE, 16'sd0);
        issue_event(CMD_TICK, DIR_UP, 16'sd10);
        issue_event(CMD_LEFT, DIR_UP, 16'sd20);
        issue_event(CMD_TICK, DIR_UP, 16'sh7FFF);
        issue_event(CMD_ARRIVED, DIR_IDLE, 16'sd400);
        issue_event(CMD_DOORS_OPEN, DIR_IDLE, 16'sd400);
        issue_event(CMD_TICK, DIR_IDLE, 16'sd400);
        issue_event(CMD_FLOOR1, DIR_DOWN, 16'sd420);
        issue_event(CMD_FLOOR2, DIR_DOWN, 16'sd421);
        issue_event(CMD_FLOOR3, DIR_IDLE, 16'sd0);
        issue_event(CMD_UNUSED_LO, DIR_INVALID, 16'sh7FFF);
        issue_event(CMD_TICK, DIR_INVALID, 16'sd0);
        issue_event(CMD_TICK, DIR_IDLE, 16'sd0);
        issue_event(CMD_TICK, DIR_IDLE, 16'sd0);
        drain_results();

        // random phases, each under its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: regs = '{16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom_range(0, 200)), 16'd3};
                1: regs = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd0};
                2: regs = '{16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF};
                3: regs = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom_range(0, 10))};
                4: regs = '{16'd0, 16'd400, 16'd800, 16'd20, 16'd6};
                default: regs = '{16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom_range(0, 50)), 16'd2};
            endcase
            write_reg(REG_FLOOR1_POS, regs[0]);
            write_reg(REG_FLOOR2_POS, regs[1]);
            write_reg(REG_FLOOR3_POS, regs[2]);
            write_reg(REG_SAFE_STOP, regs[3]);
            write_reg(REG_DWELL_TICKS, regs[4]);
            if (phase == 4) write_reg(REG_UNUSED, 16'($urandom));
            floor_pos[0] = int'(signed'(regs[0]));
            floor_pos[1] = int'(signed'(regs[1]));
            floor_pos[2] = int'(signed'(regs[2]));
            margin_now   = int'(regs[3][14:0]);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                kind = $urandom_range(0, 9);
                if (kind < 6) begin
                    // trip: calls, doors shut, target issued, travel, arrival, dwell
                    n = $urandom_range(1, 4);
                    repeat (n) issue_event(pick_button(), any_dir(), pick_pos());
                    issue_event(CMD_DOORS_CLOSED, DIR_IDLE, pick_pos());
                    n = $urandom_range(1, 3);
                    repeat (n) issue_event(CMD_TICK, moving_dir(), pick_pos());
                    issue_event(CMD_LEFT, moving_dir(), pick_pos());
                    n = $urandom_range(0, 4);
                    repeat (n) begin
                        if ($urandom_range(0, 3) == 0)
                            issue_event(pick_button(), moving_dir(), pick_pos());
                        issue_event(CMD_TICK, moving_dir(), pick_pos());
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        issue_event(CMD_STOP_PRESS, any_dir(), pick_pos());
                        issue_event(CMD_STOP_RELEASE, any_dir(), pick_pos());
                    end
                    issue_event(CMD_ARRIVED, DIR_IDLE, pick_pos());
                    issue_event(CMD_DOORS_OPEN, DIR_IDLE, pick_pos());
                    n = $urandom_range(1, 8);
                    repeat (n) issue_event(CMD_TICK, DIR_IDLE, pick_pos());
                end else if (kind == 6) begin
                    // long run of non-dwell ticks so the settle counter saturates
                    issue_event(CMD_LEFT, moving_dir(), pick_pos());
                    if ($urandom_range(0, 1)) issue_event(CMD_DOORS_CLOSED, DIR_IDLE, 16'sd0);
                    n = $urandom_range(52, 60);
                    repeat (n) issue_event(CMD_TICK, $urandom_range(0, 1) ? moving_dir()
                                                                         : DIR_INVALID, pick_pos());
                    issue_event(CMD_ARRIVED, DIR_IDLE, pick_pos());
                    n = $urandom_range(1, 4);
                    repeat (n) issue_event(CMD_TICK, DIR_IDLE, pick_pos());
                end else begin
                    // noise over every code, direction and position
                    n = $urandom_range(1, 6);
                    repeat (n) issue_event(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                                           16'($urandom));
                end
            end
            drain_results();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("elevator_floor_planner_core_tb: PASS");
        end else begin
            $display("elevator_floor_planner_core_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("elevator_floor_planner_core_tb: FAIL");
        $finish;
    end

endmodule
